@@ rtl/basic_token_lexer_unit_assert.svh @@
// Assertion macros for the token lexer.
// Used by the top level only; needs no package.
`ifndef BASIC_TOKEN_LEXER_UNIT_ASSERT_SVH
`define BASIC_TOKEN_LEXER_UNIT_ASSERT_SVH
// Implication checked on every edge outside reset.
`define BTL_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication outside reset.
`define BTL_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

@@ rtl/btl_pkg.sv @@
// Shared types, token codes and keyword table for the token lexer.
// No dependencies.
package btl_pkg;
	localparam int MAX_NUMBER_LEN = 32;
	localparam int MAX_IDENT_LEN  = 32;
	localparam int MAX_STRING_LEN = 255;
	localparam int NKW = 41;
	localparam int KWW = 10;
	// token queue depth, power of two, at least four
	localparam int QUEUE_DEPTH = 8;

	localparam logic [5:0] K_EOF = 6'd0;
	localparam logic [5:0] K_EOL = 6'd1;
	localparam logic [5:0] K_ERR = 6'd2;
	localparam logic [5:0] K_NUM = 6'd3;
	localparam logic [5:0] K_STR = 6'd4;
	localparam logic [5:0] K_IDENT = 6'd5;
	localparam logic [5:0] K_KW_BASE = 6'd23;

	localparam logic [2:0] E_NONE = 3'd0;
	localparam logic [2:0] E_UNEXP = 3'd1;
	localparam logic [2:0] E_NUMLONG = 3'd2;
	localparam logic [2:0] E_BADNUM = 3'd3;
	localparam logic [2:0] E_IDLONG = 3'd4;
	localparam logic [2:0] E_UNTERM = 3'd5;

	typedef struct packed {
		logic [7:0] source_byte;
		logic       end_of_source;
	} in_word_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [15:0] start_line;
		logic [15:0] start_column;
		logic [7:0]  lexeme_length;
		logic [2:0]  error_code;
		logic        last_of_run;
	} out_word_t;

	// Keywords, padded with zero bytes, first character in the low byte.
	typedef logic [KWW*8-1:0] kw_entry_t;

	function automatic kw_entry_t kw_str(input int k);
		kw_entry_t r;
		r = '0;
		unique case (k)
			0: r = "tel";         1: r = "ln";         2: r = "tnirp";
			3: r = "htdiw";       4: r = "tfel";       5: r = "thgir";
			6: r = "retnec";      7: r = "rolocon";    8: r = "kcalb";
			9: r = "der";         10: r = "neerg";     11: r = "wolley";
			12: r = "eulb";       13: r = "atnegam";   14: r = "nayc";
			15: r = "etihw";      16: r = "derb";      17: r = "neergb";
			18: r = "wolleyb";    19: r = "eulbb";     20: r = "atnegamb";
			21: r = "naycb";      22: r = "etihwb";    23: r = "kcalbgb";
			24: r = "dergb";      25: r = "neerggb";   26: r = "wolleygb";
			27: r = "eulbgb";     28: r = "atnegamgb"; 29: r = "naycgb";
			30: r = "etihwgb";    31: r = "tupni";     32: r = "eurt";
			33: r = "eslaf";      34: r = "fi";        35: r = "neht";
			36: r = "esle";       37: r = "dne";       38: r = "dna";
			39: r = "ro";         40: r = "ton";
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] kw_len(input int k);
		kw_entry_t s;
		logic [3:0] n;
		s = kw_str(k);
		n = '0;
		for (int i = 0; i < KWW; i++)
			if (s[i*8 +: 8] != 8'd0) n = 4'(i + 1);
		return n;
	endfunction

	function automatic logic [5:0] op_code(input logic [7:0] c);
		logic [5:0] r;
		unique case (c)
			"+": r = 6'd6;  "-": r = 6'd7;  "*": r = 6'd8;  "/": r = 6'd9;
			"(": r = 6'd10; ")": r = 6'd11; "=": r = 6'd12; "!": r = 6'd14;
			"<": r = 6'd16; ">": r = 6'd18; ":": r = 6'd20; ";": r = 6'd21;
			"?": r = 6'd22;
			default: r = 6'd0;
		endcase
		return r;
	endfunction

	// Front to back: up to two tokens produced by one byte.
	typedef struct packed {
		out_word_t t0;
		out_word_t t1;
		logic      two;
	} pair_t;
endpackage

@@ rtl/btl_scan.sv @@
// Front end: accepts bytes, runs the scanner state and builds tokens.
// Depends on btl_pkg.
module btl_scan #(
	parameter int MaxNumberLen = btl_pkg::MAX_NUMBER_LEN,
	parameter int MaxIdentLen  = btl_pkg::MAX_IDENT_LEN,
	parameter int MaxStringLen = btl_pkg::MAX_STRING_LEN
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  btl_pkg::in_word_t in_word,
	output logic             pair_valid,
	output btl_pkg::pair_t   pair
);
	localparam logic [2:0] M_IDLE = 3'd0, M_NUM = 3'd1, M_POINT = 3'd2, M_IDENT = 3'd3,
		M_STR = 3'd4, M_COMMENT = 3'd5, M_OPER = 3'd6;
	localparam logic [7:0] NUM_MAX = 8'(MaxNumberLen);
	localparam logic [7:0] ID_MAX = 8'(MaxIdentLen - 1);
	localparam logic [7:0] STR_MAX = 8'(MaxStringLen - 1);

	logic [2:0] mode_q, mode_d;
	logic [15:0] line_q, col_q, tline_q, tcol_q, line_d, col_d, tline_d, tcol_d;
	logic [7:0] blen_q, blen_d, pop_q, pop_d;
	logic [btl_pkg::NKW-1:0] kw_q, kw_d;
	logic pt_q, pt_d, halt_q, halt_d;

	btl_pkg::out_word_t tok [2];
	logic [1:0] n;
	logic [7:0] b;
	logic eos;

	function automatic logic dig(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction
	function automatic logic alp(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	// Keyword narrowing against the byte at position pos.
	function automatic logic [btl_pkg::NKW-1:0] narrow(input logic [btl_pkg::NKW-1:0] cand,
		input logic [7:0] c, input logic [7:0] pos);
		logic [btl_pkg::NKW-1:0] r;
		btl_pkg::kw_entry_t s;
		r = cand;
		for (int k = 0; k < btl_pkg::NKW; k++) begin
			s = btl_pkg::kw_str(k);
			if (pos >= 8'(btl_pkg::KWW)) r[k] = 1'b0;
			else if (s[pos[3:0]*8 +: 8] != c) r[k] = 1'b0;
		end
		return r;
	endfunction

	// Kind of the finished word: first matching keyword of equal length.
	function automatic logic [5:0] word_kind(input logic [btl_pkg::NKW-1:0] cand,
		input logic [7:0] len);
		logic [5:0] r;
		r = btl_pkg::K_IDENT;
		for (int k = btl_pkg::NKW - 1; k >= 0; k--)
			if (cand[k] && {4'd0, btl_pkg::kw_len(k)} == len)
				r = 6'(btl_pkg::K_KW_BASE + 6'(k));
		return r;
	endfunction

	// Scanner step: next state and tokens for one byte.
	always_comb begin
		logic [5:0] op;
		logic run_idle;
		b = in_word.source_byte;
		eos = in_word.end_of_source;
		mode_d = mode_q; line_d = line_q; col_d = col_q; tline_d = tline_q; tcol_d = tcol_q;
		blen_d = blen_q; pop_d = pop_q; kw_d = kw_q; pt_d = pt_q; halt_d = halt_q;
		tok[0] = '0; tok[1] = '0; n = 2'd0; run_idle = 1'b0;
		op = btl_pkg::op_code(b);
		if (eos) begin
			if (!halt_q) begin
				unique case (mode_q)
					M_NUM: begin
						tok[0] = '{btl_pkg::K_NUM, tline_q, tcol_q, blen_q, btl_pkg::E_NONE, 1'b0};
						n = 2'd1;
					end
					M_POINT: begin
						tok[0] = '{btl_pkg::K_ERR, tline_q, tcol_q, 8'd0, btl_pkg::E_BADNUM, 1'b0};
						n = 2'd1;
					end
					M_IDENT: begin
						tok[0] = '{word_kind(kw_q, blen_q), tline_q, tcol_q, blen_q,
							btl_pkg::E_NONE, 1'b0};
						n = 2'd1;
					end
					M_STR: begin
						tok[0] = '{btl_pkg::K_ERR, tline_q, tcol_q, 8'd0, btl_pkg::E_UNTERM, 1'b0};
						n = 2'd1;
					end
					M_OPER: begin
						tok[0] = '{btl_pkg::op_code(pop_q), tline_q, tcol_q, 8'd1,
							btl_pkg::E_NONE, 1'b0};
						n = 2'd1;
					end
					default: ;
				endcase
			end
			tok[n[0]] = '{btl_pkg::K_EOF, line_q, col_q, 8'd0, btl_pkg::E_NONE, 1'b1};
			n = n + 2'd1;
			mode_d = M_IDLE; line_d = 16'd1; col_d = 16'd1; tline_d = 16'd1; tcol_d = 16'd1;
			blen_d = '0; pop_d = '0; kw_d = '1; pt_d = 1'b0; halt_d = 1'b0;
		end else begin
			if (!halt_q) begin
				unique case (mode_q)
					M_NUM: begin
						if (dig(b) || b == ".") begin
							if (blen_q >= NUM_MAX) begin
								tok[0] = '{btl_pkg::K_ERR, tline_q, tcol_q, 8'd0,
									btl_pkg::E_NUMLONG, 1'b0};
								n = 2'd1; halt_d = 1'b1; mode_d = M_IDLE;
							end else if (b == "." && pt_q) begin
								tok[0] = '{btl_pkg::K_ERR, tline_q, tcol_q, 8'd0,
									btl_pkg::E_BADNUM, 1'b0};
								n = 2'd1; halt_d = 1'b1; mode_d = M_IDLE;
							end else begin
								blen_d = blen_q + 8'd1;
								if (b == ".") begin
									pt_d = 1'b1; mode_d = M_POINT;
								end
							end
						end else begin
							tok[0] = '{btl_pkg::K_NUM, tline_q, tcol_q, blen_q,
								btl_pkg::E_NONE, 1'b0};
							n = 2'd1; run_idle = 1'b1;
						end
					end
					M_POINT: begin
						if (!dig(b)) begin
							tok[0] = '{btl_pkg::K_ERR, tline_q, tcol_q, 8'd0,
								btl_pkg::E_BADNUM, 1'b0};
							n = 2'd1; halt_d = 1'b1; mode_d = M_IDLE;
						end else if (blen_q >= NUM_MAX) begin
							tok[0] = '{btl_pkg::K_ERR, tline_q, tcol_q, 8'd0,
								btl_pkg::E_NUMLONG, 1'b0};
							n = 2'd1; halt_d = 1'b1; mode_d = M_IDLE;
						end else begin
							blen_d = blen_q + 8'd1; mode_d = M_NUM;
						end
					end
					M_IDENT: begin
						if (alp(b) || dig(b) || b == "_") begin
							if (blen_q >= ID_MAX) begin
								tok[0] = '{btl_pkg::K_ERR, tline_q, tcol_q, 8'd0,
									btl_pkg::E_IDLONG, 1'b0};
								n = 2'd1; halt_d = 1'b1; mode_d = M_IDLE;
							end else begin
								kw_d = narrow(kw_q, b, blen_q);
								blen_d = blen_q + 8'd1;
							end
						end else begin
							tok[0] = '{word_kind(kw_q, blen_q), tline_q, tcol_q, blen_q,
								btl_pkg::E_NONE, 1'b0};
							n = 2'd1; run_idle = 1'b1;
						end
					end
					M_STR: begin
						if (b == 8'h22) begin
							tok[0] = '{btl_pkg::K_STR, tline_q, tcol_q, blen_q,
								btl_pkg::E_NONE, 1'b0};
							n = 2'd1; mode_d = M_IDLE;
						end else if (b == 8'h0A || blen_q >= STR_MAX) begin
							tok[0] = '{btl_pkg::K_ERR, tline_q, tcol_q, 8'd0,
								btl_pkg::E_UNTERM, 1'b0};
							n = 2'd1; halt_d = 1'b1; mode_d = M_IDLE;
						end else begin
							blen_d = blen_q + 8'd1;
						end
					end
					M_COMMENT: run_idle = (b == 8'h0A);
					M_OPER: begin
						if (b == "=") begin
							tok[0] = '{btl_pkg::op_code(pop_q) + 6'd1, tline_q, tcol_q, 8'd2,
								btl_pkg::E_NONE, 1'b0};
							n = 2'd1; mode_d = M_IDLE;
						end else begin
							tok[0] = '{btl_pkg::op_code(pop_q), tline_q, tcol_q, 8'd1,
								btl_pkg::E_NONE, 1'b0};
							n = 2'd1; run_idle = 1'b1;
						end
					end
					default: run_idle = 1'b1;
				endcase
				// Byte in idle mode: skip a blank, start a token or a comment, or emit a one-byte token or an error.
				if (run_idle) begin
					mode_d = M_IDLE;
					if (b == " " || b == 8'h09 || b == 8'h0D) begin
					end else if (b == "#") begin
						mode_d = M_COMMENT;
					end else if (dig(b)) begin
						mode_d = M_NUM; tline_d = line_q; tcol_d = col_q; blen_d = 8'd1;
						pt_d = 1'b0;
					end else if (b == ".") begin
						mode_d = M_POINT; tline_d = line_q; tcol_d = col_q; blen_d = 8'd1;
						pt_d = 1'b1;
					end else if (alp(b) || b == "_") begin
						mode_d = M_IDENT; tline_d = line_q; tcol_d = col_q; blen_d = 8'd1;
						kw_d = narrow('1, b, 8'd0);
					end else if (b == 8'h22) begin
						mode_d = M_STR; tline_d = line_q; tcol_d = col_q; blen_d = 8'd0;
					end else if (b == 8'h0A) begin
						tok[n[0]] = '{btl_pkg::K_EOL, line_q, col_q, 8'd1, btl_pkg::E_NONE, 1'b0};
						n = n + 2'd1;
					end else if (b == "=" || b == "!" || b == "<" || b == ">") begin
						mode_d = M_OPER; tline_d = line_q; tcol_d = col_q; blen_d = 8'd1;
						pop_d = b;
					end else if (op != 6'd0) begin
						tok[n[0]] = '{op, line_q, col_q, 8'd1, btl_pkg::E_NONE, 1'b0};
						n = n + 2'd1;
					end else begin
						tok[n[0]] = '{btl_pkg::K_ERR, line_q, col_q, 8'd0, btl_pkg::E_UNEXP, 1'b0};
						n = n + 2'd1; halt_d = 1'b1;
					end
				end
			end
			// Position counters, saturating; continuation bytes keep the column.
			if (b == 8'h0A) begin
				if (line_q != 16'hFFFF) line_d = line_q + 16'd1;
				col_d = 16'd1;
			end else if (b[7:6] != 2'b10) begin
				if (col_q != 16'hFFFF) col_d = col_q + 16'd1;
			end
			if (n == 2'd2) tok[1].last_of_run = 1'b1;
			else if (n == 2'd1) tok[0].last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; line_q <= 16'd1; col_q <= 16'd1; tline_q <= 16'd1;
			tcol_q <= 16'd1; blen_q <= '0; pop_q <= '0; kw_q <= '1; pt_q <= 1'b0;
			halt_q <= 1'b0;
		end else if (in_valid) begin
			mode_q <= mode_d; line_q <= line_d; col_q <= col_d; tline_q <= tline_d;
			tcol_q <= tcol_d; blen_q <= blen_d; pop_q <= pop_d; kw_q <= kw_d; pt_q <= pt_d;
			halt_q <= halt_d;
		end
	end

	assign pair_valid = in_valid && (n != 2'd0);
	assign pair = '{tok[0], tok[1], n == 2'd2};
endmodule

@@ rtl/btl_queue.sv @@
// Back end: token queue between scanner and result port, up to two words in per push.
// Depends on btl_pkg.
module btl_queue #(
	parameter int Depth = btl_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  btl_pkg::pair_t     pair,
	output logic               room,
	output logic               empty,
	input  logic               pop,
	output btl_pkg::out_word_t head
);
	localparam int AW = $clog2(Depth);
	btl_pkg::out_word_t mem [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic do_pop;
	logic [AW:0] nin;

	assign do_pop = pop && !empty;
	assign empty = (cnt_q == '0);
	assign room = (cnt_q <= (AW+1)'(Depth - 2));
	assign nin = push ? (pair.two ? (AW+1)'(2) : (AW+1)'(1)) : '0;
	assign head = mem[rp_q];

	// Storage write; head is read from the row at the read pointer.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= pair.t0;
			if (pair.two) mem[AW'(wp_q + AW'(1))] <= pair.t1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q <= AW'(wp_q + nin[AW-1:0]);
			rp_q <= rp_q + AW'(do_pop);
			cnt_q <= cnt_q + nin - (AW+1)'(do_pop);
		end
	end
endmodule

@@ rtl/basic_token_lexer_unit.sv @@
// Top level of the streaming token lexer: scanner front end plus token queue.
// Depends on btl_pkg, btl_scan, btl_queue and the assertion macro header.
//
// One source byte is taken per clock while full is low; each byte yields zero,
// one or two tokens, which wait in an eight-word queue that drains one token
// per cycle through pop. full rises only when the queue has fewer than two free
// words, so the scanner runs at one byte a cycle as long as results are taken
// as fast as they are produced. Line and column saturate at 65535.
`include "basic_token_lexer_unit_assert.svh"
module basic_token_lexer_unit #(
	parameter int MaxNumberLen = btl_pkg::MAX_NUMBER_LEN,
	parameter int MaxIdentLen  = btl_pkg::MAX_IDENT_LEN,
	parameter int MaxStringLen = btl_pkg::MAX_STRING_LEN
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  btl_pkg::in_word_t  in_word,
	output logic               empty,
	input  logic               pop,
	output btl_pkg::out_word_t out_word
);
	logic accept, pair_valid, room;
	btl_pkg::pair_t pair;

	assign full = !room;
	assign accept = push && room;

	btl_scan #(.MaxNumberLen(MaxNumberLen), .MaxIdentLen(MaxIdentLen),
		.MaxStringLen(MaxStringLen)) u_scan (
		.clk(clk), .arst_n(arst_n), .in_valid(accept), .in_word(in_word),
		.pair_valid(pair_valid), .pair(pair));

	btl_queue #(.Depth(btl_pkg::QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(pair_valid), .pair(pair), .room(room),
		.empty(empty), .pop(pop), .head(out_word));

	// End marker always yields a closing token.
	`BTL_ASSERT_NEXT(a_eos_out, clk, arst_n, accept && in_word.end_of_source, !empty,
		"end marker gave no token")
	// Two-token words always close a run on the second.
	`BTL_ASSERT_IMP(a_two_last, clk, arst_n, pair_valid && pair.two,
		pair.t1.last_of_run && !pair.t0.last_of_run, "bad run marking")
	// Error tokens carry a code, others none.
	`BTL_ASSERT_IMP(a_err_code, clk, arst_n, pair_valid,
		(pair.t0.token_kind == btl_pkg::K_ERR) == (pair.t0.error_code != btl_pkg::E_NONE),
		"error code mismatch")
endmodule

@@ verif/tb.sv @@
// Self-checking bench for basic_token_lexer_unit: a byte stream goes in, tokens are checked.
// Depends on btl_pkg and the lexer RTL. The predictor below tracks the scanner state itself.
module tb;
	import btl_pkg::*;

	localparam int WDOG_LIMIT = 20000;
	localparam int MAX_ERRS_SHOWN = 10;

	// scanner modes of the predictor
	typedef enum logic [2:0] {
		SM_IDLE, SM_NUM, SM_POINT, SM_IDENT, SM_STR, SM_COMMENT, SM_OPER
	} scan_mode_e;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	in_word_t in_word;
	logic empty;
	logic pop;
	out_word_t out_word;

	basic_token_lexer_unit u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_word(in_word),
		.empty(empty), .pop(pop), .out_word(out_word)
	);

	// predictor state
	scan_mode_e mode_q;
	logic [15:0] line_q, col_q, tok_line_q, tok_col_q;
	logic [7:0] body_len_q;
	logic [40:0] kw_cand_q;
	logic [7:0] pend_op_q;
	logic seen_point_q;
	logic halted_q;

	in_word_t byte_queue[$];
	out_word_t token_queue[$];
	out_word_t step_out[$];
	int mismatches;
	int watchdog;
	bit stim_done;
	bit hold_send;
	int send_gap;
	int pop_gap;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic [5:0] oper_kind(logic [7:0] c);
		case (c)
			"+": return 6'd6;  "-": return 6'd7;  "*": return 6'd8;  "/": return 6'd9;
			"(": return 6'd10; ")": return 6'd11; "=": return 6'd12; "!": return 6'd14;
			"<": return 6'd16; ">": return 6'd18; ":": return 6'd20; ";": return 6'd21;
			"?": return 6'd22;
			default: return 6'd0;
		endcase
	endfunction

	// keyword spellings, in token-code order
	string kw_words[NKW] = '{
		"let", "nl", "print", "width", "left", "right", "center", "nocolor",
		"black", "red", "green", "yellow", "blue", "magenta", "cyan", "white",
		"bred", "bgreen", "byellow", "bblue", "bmagenta", "bcyan", "bwhite",
		"bgblack", "bgred", "bggreen", "bgyellow", "bgblue", "bgmagenta",
		"bgcyan", "bgwhite", "input", "true", "false", "if", "then", "else",
		"end", "and", "or", "not"};

	task automatic emit(logic [5:0] kind, logic [15:0] ln, logic [15:0] cl,
			logic [7:0] len, logic [2:0] err);
		out_word_t w;
		w.token_kind = kind;
		w.start_line = ln;
		w.start_column = cl;
		w.lexeme_length = len;
		w.error_code = err;
		w.last_of_run = 1'b0;
		step_out.push_back(w);
	endtask

	task automatic raise_error(logic [2:0] err, logic [15:0] ln, logic [15:0] cl);
		emit(K_ERR, ln, cl, 8'd0, err);
		halted_q = 1'b1;
		mode_q = SM_IDLE;
	endtask

	task automatic narrow_kw(logic [7:0] c, int pos);
		for (int k = 0; k < NKW; k++)
			if (pos >= kw_words[k].len() || kw_words[k][pos] != c)
				kw_cand_q[k] = 1'b0;
	endtask

	function automatic logic [5:0] ident_kind();
		for (int k = 0; k < NKW; k++)
			if (kw_cand_q[k] && kw_words[k].len() == body_len_q)
				return K_KW_BASE + 6'(k);
		return K_IDENT;
	endfunction

	task automatic start_token(scan_mode_e m, logic [7:0] len);
		mode_q = m;
		tok_line_q = line_q;
		tok_col_q = col_q;
		body_len_q = len;
	endtask

	task automatic reset_lexer();
		mode_q = SM_IDLE;
		line_q = 16'd1; col_q = 16'd1; tok_line_q = 16'd1; tok_col_q = 16'd1;
		body_len_q = '0;
		kw_cand_q = '1;
		pend_op_q = '0;
		seen_point_q = 1'b0;
		halted_q = 1'b0;
	endtask

	// byte seen between tokens
	task automatic lex_fresh(logic [7:0] b);
		mode_q = SM_IDLE;
		if (b == " " || b == 8'h09 || b == 8'h0d) return;
		if (b == "#") begin
			mode_q = SM_COMMENT;
		end else if (is_digit(b)) begin
			start_token(SM_NUM, 8'd1);
			seen_point_q = 1'b0;
		end else if (b == ".") begin
			start_token(SM_POINT, 8'd1);
			seen_point_q = 1'b1;
		end else if (is_alpha(b) || b == "_") begin
			start_token(SM_IDENT, 8'd1);
			kw_cand_q = '1;
			narrow_kw(b, 0);
		end else if (b == 8'h22) begin
			start_token(SM_STR, 8'd0);
		end else if (b == 8'h0a) begin
			emit(K_EOL, line_q, col_q, 8'd1, E_NONE);
		end else if (b == "=" || b == "!" || b == "<" || b == ">") begin
			start_token(SM_OPER, 8'd1);
			pend_op_q = b;
		end else if (oper_kind(b) != 6'd0) begin
			emit(oper_kind(b), line_q, col_q, 8'd1, E_NONE);
		end else begin
			raise_error(E_UNEXP, line_q, col_q);
		end
	endtask

	task automatic step_position(logic [7:0] b);
		if (b == 8'h0a) begin
			if (line_q != 16'hffff) line_q++;
			col_q = 16'd1;
		end else if ((b & 8'hc0) != 8'h80) begin
			if (col_q != 16'hffff) col_q++;
		end
	endtask

	// expected tokens for one accepted input word
	task automatic predict_tokens(in_word_t w);
		logic [7:0] b;
		b = w.source_byte;
		step_out.delete();
		if (w.end_of_source) begin
			if (!halted_q) begin
				case (mode_q)
					SM_NUM: emit(K_NUM, tok_line_q, tok_col_q, body_len_q, E_NONE);
					SM_POINT: raise_error(E_BADNUM, tok_line_q, tok_col_q);
					SM_IDENT: emit(ident_kind(), tok_line_q, tok_col_q, body_len_q, E_NONE);
					SM_STR: raise_error(E_UNTERM, tok_line_q, tok_col_q);
					SM_OPER: emit(oper_kind(pend_op_q), tok_line_q, tok_col_q, 8'd1, E_NONE);
					default: ;
				endcase
			end
			emit(K_EOF, line_q, col_q, 8'd0, E_NONE);
			reset_lexer();
		end else if (halted_q) begin
			step_position(b);
		end else begin
			case (mode_q)
				SM_NUM: begin
					if (is_digit(b) || b == ".") begin
						if (body_len_q >= MAX_NUMBER_LEN)
							raise_error(E_NUMLONG, tok_line_q, tok_col_q);
						else if (b == "." && seen_point_q)
							raise_error(E_BADNUM, tok_line_q, tok_col_q);
						else begin
							body_len_q++;
							if (b == ".") begin
								seen_point_q = 1'b1;
								mode_q = SM_POINT;
							end
						end
					end else begin
						emit(K_NUM, tok_line_q, tok_col_q, body_len_q, E_NONE);
						lex_fresh(b);
					end
				end
				SM_POINT: begin
					if (!is_digit(b)) raise_error(E_BADNUM, tok_line_q, tok_col_q);
					else if (body_len_q >= MAX_NUMBER_LEN)
						raise_error(E_NUMLONG, tok_line_q, tok_col_q);
					else begin
						body_len_q++;
						mode_q = SM_NUM;
					end
				end
				SM_IDENT: begin
					if (is_digit(b) || is_alpha(b) || b == "_") begin
						if (body_len_q >= MAX_IDENT_LEN - 1)
							raise_error(E_IDLONG, tok_line_q, tok_col_q);
						else begin
							narrow_kw(b, body_len_q);
							body_len_q++;
						end
					end else begin
						emit(ident_kind(), tok_line_q, tok_col_q, body_len_q, E_NONE);
						lex_fresh(b);
					end
				end
				SM_STR: begin
					if (b == 8'h22) begin
						emit(K_STR, tok_line_q, tok_col_q, body_len_q, E_NONE);
						mode_q = SM_IDLE;
					end else if (b == 8'h0a || body_len_q >= MAX_STRING_LEN - 1)
						raise_error(E_UNTERM, tok_line_q, tok_col_q);
					else
						body_len_q++;
				end
				SM_COMMENT: begin
					if (b == 8'h0a) lex_fresh(b);
				end
				SM_OPER: begin
					if (b == "=") begin
						emit(oper_kind(pend_op_q) + 6'd1, tok_line_q, tok_col_q, 8'd2, E_NONE);
						mode_q = SM_IDLE;
					end else begin
						emit(oper_kind(pend_op_q), tok_line_q, tok_col_q, 8'd1, E_NONE);
						lex_fresh(b);
					end
				end
				default: lex_fresh(b);
			endcase
			step_position(b);
		end
		if (step_out.size() > 0) step_out[step_out.size() - 1].last_of_run = 1'b1;
		foreach (step_out[i]) token_queue.push_back(step_out[i]);
	endtask

	// stimulus helpers
	task automatic add_byte(logic [7:0] b);
		in_word_t w;
		w.source_byte = b;
		w.end_of_source = 1'b0;
		byte_queue.push_back(w);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endtask

	task automatic add_end();
		in_word_t w;
		w.source_byte = 8'($urandom_range(0, 255));
		w.end_of_source = 1'b1;
		byte_queue.push_back(w);
	endtask

	function automatic string rand_name(int n);
		string s;
		string pool;
		pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
		s = "";
		for (int i = 0; i < n; i++) begin
			if (i == 0) s = {s, string'(pool[$urandom_range(0, 52)])};
			else s = {s, string'(pool[$urandom_range(0, 62)])};
		end
		return s;
	endfunction

	function automatic string rand_digits(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
		return s;
	endfunction

	// one random piece: a token, a separator, a comment or stray bytes
	task automatic add_random_piece();
		string ops[] = '{"+", "-", "*", "/", "(", ")", "=", "==", "!", "!=", "<", "<=",
			">", ">=", ":", ";", "?"};
		int n;
		case ($urandom_range(0, 12))
			0, 1: add_text(kw_words[$urandom_range(0, NKW - 1)]);
			2: add_text(rand_name($urandom_range(1, ($urandom_range(0, 9) == 0) ? 34 : 8)));
			3: begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 35) : $urandom_range(1, 6);
				add_text(rand_digits(n));
				if ($urandom_range(0, 2) == 0) add_text({".", rand_digits($urandom_range(1, 3))});
			end
			4: begin
				add_byte(8'h22);
				n = $urandom_range(0, 10);
				for (int i = 0; i < n; i++) add_byte(8'($urandom_range(32, 126)) == 8'h22 ?
					8'h41 : 8'($urandom_range(32, 126)));
				add_byte(8'h22);
			end
			5, 6: add_text(ops[$urandom_range(0, 16)]);
			7: add_byte(8'h0a);
			8: add_text("# note\n");
			9: add_byte(8'($urandom_range(0, 255)));
			10: begin
				add_byte(8'($urandom_range(8'hc0, 8'hff)));
				add_byte(8'($urandom_range(8'h80, 8'hbf)));
			end
			default: add_byte(($urandom_range(0, 1) == 1) ? 8'h20 : 8'h09);
		endcase
		if ($urandom_range(0, 1) == 1) add_byte(8'h20);
	endtask

	// clock and reset
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	always #2 clk = ~clk;

	// stimulus
	initial begin
		string longstr;
		stim_done = 1'b0;
		hold_send = 1'b0;
		reset_lexer();
		// directed: keywords, operators, numbers, strings, and each error kind
		add_text("let x1=3.25 if a<=b then print \"hi\"\n");
		add_end();
		add_text("a==b!=c>=d<e>f!g:h;i?(1+2)*3/4-5 # rest\r\tnl");
		add_end();
		add_text("1.2.3"); add_end();
		add_text("7. "); add_end();
		add_text("9."); add_end();
		add_text(rand_digits(33)); add_end();
		add_text(rand_name(32)); add_end();
		add_text("\"open\nx"); add_end();
		add_text("\"unfinished"); add_end();
		longstr = "\"";
		for (int i = 0; i < 255; i++) longstr = {longstr, "s"};
		add_text(longstr); add_end();
		add_byte(8'h00); add_byte(8'hff); add_end();
		add_byte(8'h0c); add_end();
		add_byte(8'he2); add_byte(8'h82); add_byte(8'hac); add_text("="); add_end();
		add_text("bgmagenta bgmagentax bg _ Z9"); add_end();
		add_end();
		// random texts: mostly well-formed, some noise
		while (byte_queue.size() < 1650) begin
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(5, 30)) add_random_piece();
			end
			add_end();
		end
		// let the queue drain fully once before the tail of the stream
		wait (byte_queue.size() < 800);
		hold_send = 1'b1;
		wait (token_queue.size() == 0);
		repeat (20) @(posedge clk);
		hold_send = 1'b0;
		wait (byte_queue.size() == 0 && !push);
		stim_done = 1'b1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			in_word <= '0;
			send_gap <= 0;
		end else begin
			if (push && !full) predict_tokens(in_word);
			if (push && full) begin
				// keep offering the same word
			end else if (send_gap > 0) begin
				push <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (!hold_send && byte_queue.size() > 0) begin
				push <= 1'b1;
				in_word <= byte_queue.pop_front();
				send_gap <= gap_len();
			end else begin
				push <= 1'b0;
			end
		end
	end

	// monitor and consumer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_gap <= 0;
			mismatches <= 0;
		end else begin
			if (pop && !empty) begin
				if (token_queue.size() == 0) begin
					if (mismatches < MAX_ERRS_SHOWN)
						$display("unexpected token word %h", out_word);
					mismatches <= mismatches + 1;
				end else begin
					out_word_t exp_w;
					exp_w = token_queue.pop_front();
					if (exp_w !== out_word) begin
						if (mismatches < MAX_ERRS_SHOWN)
							$display("token mismatch: exp kind %0d line %0d col %0d",
								exp_w.token_kind, exp_w.start_line, exp_w.start_column,
								" len %0d err %0d last %0d,",
								exp_w.lexeme_length, exp_w.error_code, exp_w.last_of_run,
								" got kind %0d line %0d col %0d",
								out_word.token_kind, out_word.start_line, out_word.start_column,
								" len %0d err %0d last %0d",
								out_word.lexeme_length, out_word.error_code, out_word.last_of_run);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (pop_gap > 0) begin
				pop <= 1'b0;
				pop_gap <= pop_gap - 1;
			end else begin
				pop <= 1'b1;
				pop_gap <= gap_len();
			end
		end
	end

	// watchdog on accepted traffic
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watchdog <= 0;
		end else if ((push && !full) || (pop && !empty)) begin
			watchdog <= 0;
		end else begin
			watchdog <= watchdog + 1;
			if (watchdog >= WDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		wait (token_queue.size() == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && token_queue.size() == 0 && empty) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/btl_pkg.sv
rtl/btl_scan.sv
rtl/btl_queue.sv
rtl/basic_token_lexer_unit.sv
verif/tb.sv
